// ----- rtl/core/pdba_pkg.sv -----
// ----------------------------------------------------------------------------
// pdba_pkg
// Shared types and constants of the 2x box-average downsampler.
// ----------------------------------------------------------------------------
package pdba_pkg;

  localparam int MaxOutWidth = 2048;
  localparam int AddrW       = $clog2(MaxOutWidth);
  localparam int SampleW     = 16;
  localparam int SumW        = SampleW + 1;
  localparam int ColW        = 12;
  localparam int WidthW      = $clog2(MaxOutWidth + 1);
  localparam int CmpW        = (ColW + 1 > WidthW) ? ColW + 1 : WidthW;
  localparam int ClipMax     = 255;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = ColW;

  localparam logic [CfgIdxW-1:0] CfgBothDirections = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClipTo8bit     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOutWidth       = 2'd2;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] result_pixel;
    logic               row_end;
  } out_item_t;

  typedef struct packed {
    logic            both_directions;
    logic            clip_to_8bit;
    logic [ColW-1:0] out_width;
  } cfg_t;

  // Decoded work for one completed horizontal pair.
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [AddrW-1:0] addr;
    logic             store;
    logic             emit;
    logic             avg4;
    logic             last;
  } pair_t;

endpackage

// ----- rtl/core/pdba_ram.sv -----
// ----------------------------------------------------------------------------
// pdba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pdba_ram #(
  parameter int Width = 17,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/pdba_pos.sv -----
// ----------------------------------------------------------------------------
// pdba_pos
// Raster position tracking and pair forming for the downsampler.
// ----------------------------------------------------------------------------
module pdba_pos (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  pdba_pkg::in_item_t in_i,
  input  pdba_pkg::cfg_t    cfg_i,
  output pdba_pkg::pair_t   pair_o
);

  logic [pdba_pkg::SampleW-1:0] held_q, held_d;
  logic [pdba_pkg::ColW-1:0]    col_q, col_d;
  logic                         odd_q, odd_d;
  logic                         half_q, half_d;

  logic [pdba_pkg::ColW-1:0]    cur_col;
  logic                         cur_odd;
  logic                         cur_half;
  logic [pdba_pkg::WidthW-1:0]  eff_width;
  logic [pdba_pkg::CmpW-1:0]    col_ext;
  logic                         last;

  // A frame start clears the position before the flagged sample is taken.
  assign cur_col  = in_i.frame_start ? '0 : col_q;
  assign cur_odd  = in_i.frame_start ? 1'b0 : odd_q;
  assign cur_half = in_i.frame_start ? 1'b0 : half_q;

  always_comb begin
    if (cfg_i.out_width == '0) begin
      eff_width = pdba_pkg::WidthW'(1);
    end else if (int'(cfg_i.out_width) > pdba_pkg::MaxOutWidth) begin
      eff_width = pdba_pkg::WidthW'(pdba_pkg::MaxOutWidth);
    end else begin
      eff_width = pdba_pkg::WidthW'(cfg_i.out_width);
    end
  end

  assign col_ext = pdba_pkg::CmpW'(cur_col);
  assign last    = (col_ext + pdba_pkg::CmpW'(1)) >= pdba_pkg::CmpW'(eff_width);

  always_comb begin
    pair_o.sum   = pdba_pkg::SumW'(held_q) + pdba_pkg::SumW'(in_i.sample);
    if (col_ext >= pdba_pkg::CmpW'(pdba_pkg::MaxOutWidth)) begin
      pair_o.addr = pdba_pkg::AddrW'(pdba_pkg::MaxOutWidth - 1);
    end else begin
      pair_o.addr = pdba_pkg::AddrW'(col_ext);
    end
    pair_o.store = cur_half & cfg_i.both_directions & ~cur_odd;
    pair_o.emit  = cur_half & (~cfg_i.both_directions | cur_odd);
    pair_o.avg4  = cfg_i.both_directions;
    pair_o.last  = last;
  end

  always_comb begin
    held_d = held_q;
    col_d  = col_q;
    odd_d  = odd_q;
    half_d = half_q;
    if (accept_i) begin
      if (!cur_half) begin
        held_d = in_i.sample;
        half_d = 1'b1;
        col_d  = cur_col;
        odd_d  = cur_odd;
      end else begin
        half_d = 1'b0;
        if (last) begin
          col_d = '0;
          odd_d = ~cur_odd;
        end else begin
          col_d = cur_col + pdba_pkg::ColW'(1);
          odd_d = cur_odd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      col_q  <= '0;
      odd_q  <= 1'b0;
      half_q <= 1'b0;
    end else begin
      held_q <= held_d;
      col_q  <= col_d;
      odd_q  <= odd_d;
      half_q <= half_d;
    end
  end

endmodule

// ----- rtl/core/pdba_avg.sv -----
// ----------------------------------------------------------------------------
// pdba_avg
// Pair stage and result register: rounding, clamping and output handshake.
// ----------------------------------------------------------------------------
module pdba_avg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  pdba_pkg::pair_t            pair_i,
  input  logic                       clip_i,
  input  logic [pdba_pkg::SumW-1:0]  line_sum_i,
  output logic                       stage_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pdba_pkg::out_item_t        out_data_o
);

  logic                        s1_valid_q;
  logic [pdba_pkg::SumW-1:0]   s1_sum_q;
  logic                        s1_avg4_q;
  logic                        s1_last_q;
  logic                        s1_clip_q;

  logic                        out_valid_q;
  pdba_pkg::out_item_t         out_data_q, out_data_d;

  logic                        adv;
  logic [pdba_pkg::SumW+1:0]   sum4;
  logic [pdba_pkg::SumW:0]     sum2;
  logic [pdba_pkg::SampleW-1:0] res;

  assign adv           = ~out_valid_q | out_ready_i;
  assign stage_ready_o = ~s1_valid_q | adv;

  // The stored line sum arrives from the RAM in the same cycle as the stage.
  assign sum4 = (pdba_pkg::SumW+2)'(line_sum_i) + (pdba_pkg::SumW+2)'(s1_sum_q)
              + (pdba_pkg::SumW+2)'(2);
  assign sum2 = (pdba_pkg::SumW+1)'(s1_sum_q) + (pdba_pkg::SumW+1)'(1);

  always_comb begin
    if (s1_avg4_q) begin
      res = sum4[pdba_pkg::SampleW+1:2];
    end else begin
      res = sum2[pdba_pkg::SampleW:1];
    end
    if (s1_clip_q && (int'(res) > pdba_pkg::ClipMax)) begin
      res = pdba_pkg::SampleW'(pdba_pkg::ClipMax);
    end
    out_data_d.result_pixel = res;
    out_data_d.row_end      = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_sum_q  <= pair_i.sum;
      s1_avg4_q <= pair_i.avg4;
      s1_last_q <= pair_i.last;
      s1_clip_q <= clip_i;
    end
    if (adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/pixel_downsample_2x_box_average.sv -----
// ----------------------------------------------------------------------------
// pixel_downsample_2x_box_average
// 2x box-filter downsampler for a raster stream of 16-bit samples.
// ----------------------------------------------------------------------------
// Input samples arrive in raster order on the in_* valid/ready channel, rows
// of twice out_width samples; frame_start marks the first sample of a frame.
// Each horizontal pair gives one result on the out_* channel in horizontal
// mode; in both-directions mode even-row pair sums go to a 2048-entry line
// store and each odd-row pair gives the rounded 2x2 mean. row_end marks the
// last result of an output row.
// One sample is taken per cycle while in_ready_o is high. The pair stage and
// the registered line-store read load when the request carrying the second
// sample of its pair is accepted; the result register loads from the stage.
// When the receiver stalls, the result register and the pair stage fill and
// in_ready_o drops; with one free stage, input requests keep flowing.
// Configuration is written on the cfg_* channel (always ready) while idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset clears position and handshake state and loads the register defaults;
// the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pixel_downsample_2x_box_average (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pdba_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pdba_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pdba_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pdba_pkg::CfgDataW-1:0]   cfg_data_i
);

  pdba_pkg::cfg_t   cfg_q;
  pdba_pkg::pair_t  pair;
  logic             accept;
  logic             stage_ready;
  logic             ram_we;
  logic             ram_re;
  logic [pdba_pkg::SumW-1:0] line_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.both_directions <= 1'b1;
      cfg_q.clip_to_8bit    <= 1'b0;
      cfg_q.out_width       <= pdba_pkg::ColW'(960);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pdba_pkg::CfgBothDirections: cfg_q.both_directions <= cfg_data_i[0];
        pdba_pkg::CfgClipTo8bit:     cfg_q.clip_to_8bit    <= cfg_data_i[0];
        pdba_pkg::CfgOutWidth:       cfg_q.out_width       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = stage_ready;
  assign accept     = in_valid_i & stage_ready;

  pdba_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .cfg_i    (cfg_q),
    .pair_o   (pair)
  );

  assign ram_we = accept & pair.store;
  assign ram_re = accept & pair.emit & pair.avg4;

  pdba_ram #(
    .Width (pdba_pkg::SumW),
    .Depth (pdba_pkg::MaxOutWidth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pair.addr),
    .wdata_i (pair.sum),
    .re_i    (ram_re),
    .raddr_i (pair.addr),
    .rdata_o (line_sum)
  );

  pdba_avg u_avg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept & pair.emit),
    .pair_i        (pair),
    .clip_i        (cfg_q.clip_to_8bit),
    .line_sum_i    (line_sum),
    .stage_ready_o (stage_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

`ifndef SYNTHESIS
  // A pair either fills the line store or reads it, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("line store written and read by the same pair");

  // Input is held off only while a finished result is stalled at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // A line-store read leads to a valid output from the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> ##1 out_valid_o)
    else $error("line-store read did not produce a result");
`endif

endmodule
